// ----- rtl/pcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and codes of the page cache directory.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned PAGE_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BYPASS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd3;

  // per-cycle commands broadcast to every cell of the list
  typedef struct packed {
    logic match;       // compare tags with the key
    logic cap;         // propagate the marked entry towards the tail
    logic walk_start;  // place the walk token on the tail cell
    logic walk;        // move the token one cell towards the head
    logic upd;         // apply the list update
    logic shift;       // close the gap left by the marked entry
  } cell_ctrl_t;

endpackage

// ----- rtl/pcd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_cell
// One position of the fill-order list: slot, tag and use count, plus the
// mark, carry and walk-token bits that pass between neighbours.
// ----------------------------------------------------------------------------
module pcd_cell import pcd_pkg::*; #(
  parameter int unsigned TAG_BITS = 32,
  parameter int unsigned SLOT_W   = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic                top_i,
  input  logic                valid_i,
  input  logic                shift_ok_i,
  input  logic                ins_here_i,
  input  logic [TAG_BITS-1:0] key_i,
  input  logic [SLOT_W-1:0]   ins_slot_i,
  input  logic [TAG_BITS-1:0] ins_tag_i,
  input  logic [CNT_W-1:0]    ins_cnt_i,
  input  logic [SLOT_W-1:0]   nxt_slot_i,
  input  logic [TAG_BITS-1:0] nxt_tag_i,
  input  logic [CNT_W-1:0]    nxt_cnt_i,
  input  logic                prv_f_i,
  input  logic [SLOT_W-1:0]   prv_c_slot_i,
  input  logic [TAG_BITS-1:0] prv_c_tag_i,
  input  logic [CNT_W-1:0]    prv_c_cnt_i,
  input  logic                up_tok_i,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [TAG_BITS-1:0] tag_o,
  output logic [CNT_W-1:0]    cnt_o,
  output logic                f_o,
  output logic [SLOT_W-1:0]   c_slot_o,
  output logic [TAG_BITS-1:0] c_tag_o,
  output logic [CNT_W-1:0]    c_cnt_o,
  output logic                tok_o,
  output logic                tok_pass_o
);

  logic [SLOT_W-1:0]   slot_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SLOT_W-1:0]   c_slot_q;
  logic [TAG_BITS-1:0] c_tag_q;
  logic [CNT_W-1:0]    c_cnt_q;
  logic                r_q;
  logic                f_q;
  logic                tok_q;
  logic                hit_zero;

  assign hit_zero = tok_q & valid_i & (cnt_q == CNT_ONE);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      if (ins_here_i) begin
        slot_q <= ins_slot_i;
        tag_q  <= ins_tag_i;
        cnt_q  <= ins_cnt_i;
      end else if (ctrl_i.shift && f_q && shift_ok_i) begin
        slot_q <= nxt_slot_i;
        tag_q  <= nxt_tag_i;
        cnt_q  <= nxt_cnt_i;
      end
    end else if (ctrl_i.walk && tok_q && valid_i) begin
      cnt_q <= cnt_q - CNT_ONE;
    end
    if (ctrl_i.cap) begin
      if (r_q) begin
        c_slot_q <= slot_q;
        c_tag_q  <= tag_q;
        c_cnt_q  <= cnt_q;
      end else begin
        c_slot_q <= prv_c_slot_i;
        c_tag_q  <= prv_c_tag_i;
        c_cnt_q  <= prv_c_cnt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= 1'b0;
      f_q   <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      if (ctrl_i.match) begin
        r_q   <= valid_i & (tag_q == key_i);
        tok_q <= 1'b0;
      end
      if (ctrl_i.cap) begin
        f_q <= prv_f_i | r_q;
      end
      if (ctrl_i.walk_start) begin
        tok_q <= top_i;
        r_q   <= 1'b0;
      end
      if (ctrl_i.walk) begin
        tok_q <= up_tok_i;
        if (hit_zero) begin
          r_q <= 1'b1;
        end
      end
    end
  end

  // the token stops on the cell whose count reaches zero
  assign tok_pass_o = tok_q & ~hit_zero;
  assign tok_o      = tok_q;
  assign slot_o     = slot_q;
  assign tag_o      = tag_q;
  assign cnt_o      = cnt_q;
  assign f_o        = f_q;
  assign c_slot_o   = c_slot_q;
  assign c_tag_o    = c_tag_q;
  assign c_cnt_o    = c_cnt_q;

endmodule

// ----- rtl/page_cache_directory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_cache_directory
// Tag directory and use-count replacement for a page cache, built as a row
// of list cells plus a shifting queue of empty slots.
// ----------------------------------------------------------------------------
// channel | signals                                        | direction
// in      | in_valid_i, in_ready_o, page_no_i, fill_ok_i   | item in
// out     | out_valid_o, out_ready_i, status_o, slot_o,    | result out
//         | evicted_valid_o, evicted_page_o                |
//
// One item at a time. A hit, or a miss with an empty slot, passes through match,
// mark carry and update; a miss on a full cache adds the walk and a second carry.
// The time taken is set by the mark carry along the cell row and by the walk
// token, each moving one cell per cycle.
// Reset is asynchronous; the empty queue reloads slots in order at once.
// A result waiting on out_ready_i holds the block before its next result.
// ----------------------------------------------------------------------------
module page_cache_directory import pcd_pkg::*; #(
  parameter int unsigned NUM_PAGES = 64,
  parameter int unsigned TAG_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PAGE_W-1:0]     page_no_i,
  input  logic                  fill_ok_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic                  evicted_valid_o,
  output logic [PAGE_W-1:0]     evicted_page_o
);

  localparam int unsigned SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned LEN_W  = $clog2(NUM_PAGES + 1);
  localparam logic [LEN_W-1:0] LAST = LEN_W'(NUM_PAGES - 1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_CAP    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WSTART = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_UPD    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOT_OUT_W-1:0] e;
    e = {{SLOT_OUT_W{1'b0}}, s};
    return e[SLOT_OUT_W-1:0];
  endfunction

  logic [2:0]          state_q;
  logic [LEN_W-1:0]    ctr_q;
  logic                walked_q;
  logic [TAG_BITS-1:0] key_q;
  logic                fill_ok_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    ecnt_q;
  logic [LEN_W-1:0]    len_nxt_q;

  logic                upd_shift_q;
  logic                upd_ins_q;
  logic [LEN_W-1:0]    ins_pos_q;
  logic [SLOT_W-1:0]   ins_slot_q;
  logic [TAG_BITS-1:0] ins_tag_q;
  logic [CNT_W-1:0]    ins_cnt_q;
  logic                fpop_q;
  logic                fpush_q;
  logic [SLOT_W-1:0]   fpush_slot_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic                res_ev_q;
  logic [PAGE_W-1:0]   res_evp_q;

  logic [LEN_W-1:0]    len_nxt_d;
  logic                upd_shift_d;
  logic                upd_ins_d;
  logic [LEN_W-1:0]    ins_pos_d;
  logic [SLOT_W-1:0]   ins_slot_d;
  logic [TAG_BITS-1:0] ins_tag_d;
  logic [CNT_W-1:0]    ins_cnt_d;
  logic                fpop_d;
  logic                fpush_d;
  logic [SLOT_W-1:0]   fpush_slot_d;
  logic [STATUS_W-1:0] res_status_d;
  logic [SLOT_W-1:0]   res_slot_d;
  logic                res_ev_d;
  logic [PAGE_W-1:0]   res_evp_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_ev_q;
  logic [PAGE_W-1:0]   out_evp_q;

  logic [SLOT_W-1:0]   fq_q [NUM_PAGES];
  logic [LEN_W-1:0]    push_pos;

  logic [TAG_BITS+PAGE_W-1:0] key_ext;
  logic [TAG_BITS+PAGE_W-1:0] evp_ext;
  logic [TAG_BITS-1:0]        key_in;

  cell_ctrl_t ctrl;

  logic [SLOT_W-1:0]   slot_w   [NUM_PAGES];
  logic [TAG_BITS-1:0] tag_w    [NUM_PAGES];
  logic [CNT_W-1:0]    cnt_w    [NUM_PAGES];
  logic [SLOT_W-1:0]   cs_w     [NUM_PAGES];
  logic [TAG_BITS-1:0] ct_w     [NUM_PAGES];
  logic [CNT_W-1:0]    cc_w     [NUM_PAGES];
  logic [NUM_PAGES-1:0] f_w;
  logic [NUM_PAGES-1:0] tok_w;
  logic [NUM_PAGES-1:0] tp_w;

  logic [SLOT_W-1:0]   top_slot;
  logic [TAG_BITS-1:0] top_tag;
  logic [CNT_W-1:0]    top_cnt;
  logic                top_f;

  function automatic logic [SLOT_W-1:0] nxt_q_entry(input int unsigned idx);
    logic [SLOT_W-1:0] v;
    v = fq_q[idx];
    for (int unsigned k = 0; k + 1 < NUM_PAGES; k++) begin
      if (k == idx) begin
        v = fq_q[k+1];
      end
    end
    return v;
  endfunction

  assign key_ext  = {{TAG_BITS{1'b0}}, page_no_i};
  assign key_in   = key_ext[TAG_BITS-1:0];
  assign top_slot = cs_w[NUM_PAGES-1];
  assign top_tag  = ct_w[NUM_PAGES-1];
  assign top_cnt  = cc_w[NUM_PAGES-1];
  assign top_f    = f_w[NUM_PAGES-1];
  assign evp_ext  = {{PAGE_W{1'b0}}, top_tag};
  assign push_pos = fpop_q ? (ecnt_q - LEN_ONE) : ecnt_q;

  always_comb begin
    ctrl            = '0;
    ctrl.match      = (state_q == S_MATCH);
    ctrl.cap        = (state_q == S_CAP);
    ctrl.walk_start = (state_q == S_WSTART);
    ctrl.walk       = (state_q == S_WALK);
    ctrl.upd        = (state_q == S_UPD);
    ctrl.shift      = upd_shift_q;
  end

  for (genvar j = 0; j < NUM_PAGES; j++) begin : g_cell
    logic [SLOT_W-1:0]   nxt_slot;
    logic [TAG_BITS-1:0] nxt_tag;
    logic [CNT_W-1:0]    nxt_cnt;
    logic                prv_f;
    logic [SLOT_W-1:0]   prv_slot;
    logic [TAG_BITS-1:0] prv_tag;
    logic [CNT_W-1:0]    prv_cnt;
    logic                up_tok;

    if (j < NUM_PAGES - 1) begin : g_up
      assign nxt_slot = slot_w[j+1];
      assign nxt_tag  = tag_w[j+1];
      assign nxt_cnt  = cnt_w[j+1];
      assign up_tok   = tp_w[j+1];
    end else begin : g_up_end
      assign nxt_slot = '0;
      assign nxt_tag  = '0;
      assign nxt_cnt  = '0;
      assign up_tok   = 1'b0;
    end

    if (j > 0) begin : g_dn
      assign prv_f    = f_w[j-1];
      assign prv_slot = cs_w[j-1];
      assign prv_tag  = ct_w[j-1];
      assign prv_cnt  = cc_w[j-1];
    end else begin : g_dn_end
      assign prv_f    = 1'b0;
      assign prv_slot = '0;
      assign prv_tag  = '0;
      assign prv_cnt  = '0;
    end

    pcd_cell #(
      .TAG_BITS (TAG_BITS),
      .SLOT_W   (SLOT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .top_i        (j == NUM_PAGES - 1),
      .valid_i      (len_q > LEN_W'(j)),
      .shift_ok_i   (len_q > LEN_W'(j + 1)),
      .ins_here_i   (upd_ins_q && (ins_pos_q == LEN_W'(j))),
      .key_i        (key_q),
      .ins_slot_i   (ins_slot_q),
      .ins_tag_i    (ins_tag_q),
      .ins_cnt_i    (ins_cnt_q),
      .nxt_slot_i   (nxt_slot),
      .nxt_tag_i    (nxt_tag),
      .nxt_cnt_i    (nxt_cnt),
      .prv_f_i      (prv_f),
      .prv_c_slot_i (prv_slot),
      .prv_c_tag_i  (prv_tag),
      .prv_c_cnt_i  (prv_cnt),
      .up_tok_i     (up_tok),
      .slot_o       (slot_w[j]),
      .tag_o        (tag_w[j]),
      .cnt_o        (cnt_w[j]),
      .f_o          (f_w[j]),
      .c_slot_o     (cs_w[j]),
      .c_tag_o      (ct_w[j]),
      .c_cnt_o      (cc_w[j]),
      .tok_o        (tok_w[j]),
      .tok_pass_o   (tp_w[j])
    );

    // empty-slot queue: front at entry zero, shifts down on a pop
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fq_q[j] <= SLOT_W'(j);
      end else if (state_q == S_UPD) begin
        if (fpush_q && (push_pos == LEN_W'(j))) begin
          fq_q[j] <= fpush_slot_q;
        end else if (fpop_q) begin
          fq_q[j] <= nxt_q_entry(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctr_q       <= '0;
      walked_q    <= 1'b0;
      len_q       <= '0;
      ecnt_q      <= LEN_W'(NUM_PAGES);
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          walked_q <= 1'b0;
          ctr_q    <= '0;
          state_q  <= S_CAP;
        end
        S_CAP: begin
          ctr_q <= ctr_q + LEN_ONE;
          if (ctr_q == LAST) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!walked_q && !top_f && (ecnt_q == '0)) begin
            state_q <= S_WSTART;
          end else begin
            state_q <= S_UPD;
          end
        end
        S_WSTART: begin
          ctr_q   <= '0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (ctr_q == LAST) begin
            ctr_q    <= '0;
            walked_q <= 1'b1;
            state_q  <= S_CAP;
          end else begin
            ctr_q <= ctr_q + LEN_ONE;
          end
        end
        S_UPD: begin
          len_q   <= len_nxt_q;
          ecnt_q  <= ecnt_q + LEN_W'(fpush_q) - LEN_W'(fpop_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    upd_shift_d  = 1'b0;
    upd_ins_d    = 1'b0;
    fpop_d       = 1'b0;
    fpush_d      = 1'b0;
    fpush_slot_d = top_slot;
    ins_pos_d    = len_q - LEN_ONE;
    ins_slot_d   = top_slot;
    ins_tag_d    = key_q;
    ins_cnt_d    = CNT_ONE;
    len_nxt_d    = len_q;
    res_status_d = ST_BYPASS;
    res_slot_d   = top_slot;
    res_ev_d     = 1'b0;
    res_evp_d    = '0;
    if (!walked_q) begin
      if (top_f) begin
        // hit: move the entry to the tail with its count raised
        upd_shift_d  = 1'b1;
        upd_ins_d    = 1'b1;
        ins_tag_d    = top_tag;
        ins_cnt_d    = (top_cnt == CNT_MAX) ? top_cnt : top_cnt + CNT_ONE;
        res_status_d = ST_HIT;
      end else begin
        // take the front of the empty queue
        fpop_d       = 1'b1;
        ins_pos_d    = len_q;
        ins_slot_d   = fq_q[0];
        fpush_slot_d = fq_q[0];
        res_slot_d   = fq_q[0];
        if (fill_ok_q) begin
          upd_ins_d    = 1'b1;
          len_nxt_d    = len_q + LEN_ONE;
          res_status_d = ST_FILL;
        end else begin
          fpush_d      = 1'b1;
          res_status_d = ST_FAIL;
        end
      end
    end else if (top_f) begin
      // victim found by the walk
      upd_shift_d = 1'b1;
      res_ev_d    = 1'b1;
      res_evp_d   = evp_ext[PAGE_W-1:0];
      if (fill_ok_q) begin
        upd_ins_d    = 1'b1;
        res_status_d = ST_FILL;
      end else begin
        fpush_d      = 1'b1;
        len_nxt_d    = len_q - LEN_ONE;
        res_status_d = ST_FAIL;
      end
    end else begin
      res_status_d = ST_BYPASS;
      res_slot_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      key_q     <= key_in;
      fill_ok_q <= fill_ok_i;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_ev_q     <= res_ev_q;
      out_evp_q    <= res_evp_q;
    end
    if (state_q == S_DECIDE) begin
      upd_shift_q  <= upd_shift_d;
      upd_ins_q    <= upd_ins_d;
      fpop_q       <= fpop_d;
      fpush_q      <= fpush_d;
      fpush_slot_q <= fpush_slot_d;
      ins_pos_q    <= ins_pos_d;
      ins_slot_q   <= ins_slot_d;
      ins_tag_q    <= ins_tag_d;
      ins_cnt_q    <= ins_cnt_d;
      len_nxt_q    <= len_nxt_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_ev_q     <= res_ev_d;
      res_evp_q    <= res_evp_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = slot_out(out_slot_q);
  assign evicted_valid_o = out_ev_q;
  assign evicted_page_o  = out_evp_q;

  // every slot is either listed or queued as empty between items
  a_slot_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((32'(len_q) + 32'(ecnt_q)) == NUM_PAGES))
    else $error("slot count lost");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_w) <= 1)
    else $error("more than one walk token");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_HIT || status_o == ST_BYPASS)) |-> !evicted_valid_o)
    else $error("eviction reported without a miss fill");

  a_walk_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSTART) |-> (ecnt_q == '0 && len_q == LAST + LEN_ONE))
    else $error("walk started with empty slots left");

endmodule

// ----- test/page_cache_directory_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_cache_directory_checker
// Watches both channels of the page cache directory, tracks its own copy of
// the slot tags, use counts, fill-order list and empty queue, and compares
// every result with the predicted one.
// ----------------------------------------------------------------------------
module page_cache_directory_checker import pcd_pkg::*; #(
  parameter int unsigned NUM_PAGES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PAGE_W-1:0]     page_no_i,
  input  logic                  fill_ok_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [SLOT_OUT_W-1:0] slot_i,
  input  logic                  evicted_valid_i,
  input  logic [PAGE_W-1:0]     evicted_page_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    n_results_o,
  output int                    n_evictions_o,
  output int                    n_bypass_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  ev_valid;
    logic [PAGE_W-1:0]     ev_page;
  } lookup_res_t;

  logic [PAGE_W-1:0] tag_q [NUM_PAGES];
  logic [CNT_W-1:0]  use_q [NUM_PAGES];
  int                order_q [$];
  int                free_q [$];
  lookup_res_t       awaited_q [$];

  function automatic lookup_res_t lookup_page(logic [PAGE_W-1:0] page, logic ok);
    lookup_res_t r;
    int s;
    bit got;
    r = '0;
    got = 0;
    s = 0;
    for (int i = 0; i < order_q.size(); i++) begin
      if (tag_q[order_q[i]] == page) begin
        s = order_q[i];
        if (use_q[s] != CNT_MAX) use_q[s]++;
        order_q.delete(i);
        order_q.push_back(s);
        r.status = ST_HIT;
        r.slot = SLOT_OUT_W'(s);
        return r;
      end
    end
    if (free_q.size() > 0) begin
      s = free_q.pop_front();
      got = 1;
    end else begin
      // walk tail to head, first count to hit zero is the victim
      for (int i = order_q.size() - 1; i >= 0; i--) begin
        use_q[order_q[i]]--;
        if (use_q[order_q[i]] == '0) begin
          s = order_q[i];
          got = 1;
          r.ev_valid = 1'b1;
          r.ev_page = tag_q[s];
          order_q.delete(i);
          break;
        end
      end
    end
    if (!got) begin
      r.status = ST_BYPASS;
      return r;
    end
    if (ok) begin
      tag_q[s] = page;
      use_q[s] = CNT_ONE;
      order_q.push_back(s);
      r.status = ST_FILL;
    end else begin
      free_q.push_back(s);
      r.status = ST_FAIL;
    end
    r.slot = SLOT_OUT_W'(s);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PAGE_W-1:0] got,
                                 logic [PAGE_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    n_results_o = 0;
    n_evictions_o = 0;
    n_bypass_o = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      free_q.push_back(i);
      tag_q[i] = '0;
      use_q[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    lookup_res_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) awaited_q.push_back(lookup_page(page_no_i, fill_ok_i));
      if (out_valid_i && out_ready_i) begin
        n_results_o++;
        if (awaited_q.size() == 0) begin
          $display("%0t: result with none expected", $realtime);
          errors_o++;
        end else begin
          w = awaited_q.pop_front();
          if (status_i != w.status)
            report_mismatch("status", PAGE_W'(status_i), PAGE_W'(w.status));
          if (slot_i != w.slot)
            report_mismatch("slot", PAGE_W'(slot_i), PAGE_W'(w.slot));
          if (evicted_valid_i != w.ev_valid)
            report_mismatch("evicted_valid", PAGE_W'(evicted_valid_i),
                            PAGE_W'(w.ev_valid));
          if (evicted_page_i != w.ev_page)
            report_mismatch("evicted_page", evicted_page_i, w.ev_page);
          if (w.ev_valid) n_evictions_o++;
          if (w.status == ST_BYPASS) n_bypass_o++;
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ----- test/page_cache_directory_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_cache_directory_tb
// Directed and random page requests against the page cache directory, with
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module page_cache_directory_tb import pcd_pkg::*;;

  localparam int unsigned NUM_PAGES = 64;
  localparam int unsigned N_RANDOM  = 1900;
  localparam int unsigned WATCHDOG  = 20000;

  logic                  clk_i, rst_ni;
  logic                  in_valid_i, in_ready_o, fill_ok_i;
  logic [PAGE_W-1:0]     page_no_i;
  logic                  out_valid_o, out_ready_i, evicted_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_OUT_W-1:0] slot_o;
  logic [PAGE_W-1:0]     evicted_page_o;
  int errors, pending, n_results, n_evictions, n_bypass;
  int idle_cycles;
  bit sending_done, long_stall;

  page_cache_directory #(.NUM_PAGES(NUM_PAGES)) u_dut (.*);

  page_cache_directory_checker #(.NUM_PAGES(NUM_PAGES)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .page_no_i, .fill_ok_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o), .slot_i(slot_o),
    .evicted_valid_i(evicted_valid_o), .evicted_page_i(evicted_page_o),
    .errors_o(errors), .pending_o(pending), .n_results_o(n_results),
    .n_evictions_o(n_evictions), .n_bypass_o(n_bypass)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // valid drops only across a gap, so it is driven once per edge
  task automatic send_page(logic [PAGE_W-1:0] page, logic ok);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_no_i  <= page;
    fill_ok_i  <= ok;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver: random gaps, plus one long hold-off early in the random part
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (2000) @(posedge clk_i);
        long_stall = 0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [PAGE_W-1:0] base, page;
    int mode;
    in_valid_i = 1'b0;
    page_no_i  = '0;
    fill_ok_i  = 1'b0;
    sending_done = 0;
    long_stall = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: field extremes, failed fill, hit, saturation-free re-hits
    send_page('0, 1'b1);
    send_page('1, 1'b1);
    send_page('1, 1'b1);
    send_page(32'h5555_5555, 1'b0);
    send_page(32'hAAAA_AAAA, 1'b1);
    send_page('0, 1'b1);
    send_page(32'h8000_0000, 1'b0);
    send_page(32'h0000_0001, 1'b1);
    // fill the cache, then miss on a full cache: evictions and a failed
    // fill after eviction
    for (int i = 0; i < NUM_PAGES; i++) send_page(32'h100 + i, 1'b1);
    send_page(32'h200, 1'b1);
    send_page(32'h201, 1'b0);
    send_page(32'h202, 1'b1);
    long_stall = 1;
    base = $urandom();
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) page = base + $urandom_range(0, 95);     // reuse-heavy
      else if (mode < 9) page = base + $urandom_range(0, 300);
      else page = $urandom();
      if (n % 500 == 499) base = $urandom();
      send_page(page, $urandom_range(0, 7) != 0);
    end
    in_valid_i <= 1'b0;
    sending_done = 1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else if (!long_stall)
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (sending_done);
    while (pending != 0 && idle_cycles < WATCHDOG) @(posedge clk_i);
    if (pending == 0) repeat (3 * NUM_PAGES + 20) @(posedge clk_i);
    if (pending != 0 || idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", pending);
      $display("DONE: errors detected");
    end else begin
      $display("%0d results checked, %0d evictions, %0d bypasses",
               n_results, n_evictions, n_bypass);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog while stimulus is still running
  initial begin
    wait (idle_cycles >= WATCHDOG && !sending_done);
    $display("timeout while sending");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcd_pkg.sv
rtl/pcd_cell.sv
rtl/page_cache_directory.sv
test/page_cache_directory_checker.sv
test/page_cache_directory_tb.sv
